// ===== rtl/l2_directory_bank_controller_assert.svh =====
// Assertion macros for the L2 directory bank controller.
// Depends on nothing; included by the modules that carry assertions.
`ifndef L2_DIRECTORY_BANK_CONTROLLER_ASSERT_SVH
`define L2_DIRECTORY_BANK_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define L2DIR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define L2DIR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/l2dir_pkg.sv =====
// Shared constants, message codes and the set row type of the L2 directory bank.
// No dependencies; used by the row RAM and the top level.
package l2dir_pkg;

   localparam int SETS      = 512;
   localparam int WAYS      = 16;
   localparam int CORES     = 8;
   localparam int ADDR_BITS = 42;

   localparam int BANK_W = 3;
   localparam int CORE_W = 3;
   localparam int SET_W  = $clog2(SETS);
   localparam int WAY_W  = $clog2(WAYS);
   localparam int TAG_W  = ADDR_BITS - BANK_W - SET_W;
   localparam int AGE_W  = 4;
   localparam int FUNC_W = 3;
   localparam int KIND_W = 3;
   localparam int ORIG_W = 4;
   localparam int CNT_W  = 4;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;

   localparam logic [FUNC_W-1:0] FUNC_GET  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_GETX = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SWB  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_ACK  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_EWB  = 3'd4;

   localparam logic [KIND_W-1:0] MSG_GET  = 3'd0;
   localparam logic [KIND_W-1:0] MSG_GETX = 3'd1;
   localparam logic [KIND_W-1:0] MSG_PUT  = 3'd2;
   localparam logic [KIND_W-1:0] MSG_PUTX = 3'd3;
   localparam logic [KIND_W-1:0] MSG_INV  = 3'd4;

   localparam logic [ORIG_W-1:0] NO_CORE = 4'd8;

   // One set: all ways of tag, directory and LRU state side by side.
   typedef struct packed {
      logic [WAYS-1:0]             vld;
      logic [WAYS-1:0][TAG_W-1:0]  tag;
      logic [WAYS-1:0][CORES-1:0]  shr;
      logic [WAYS-1:0]             dirty;
      logic [WAYS-1:0][AGE_W-1:0]  age;
   } row_type;

endpackage

// ===== rtl/l2_directory_bank_controller.sv =====
// Flow: an item is taken, its set row is read, then 16 ways are scanned one per cycle.
// A get/getx may first send invs for an evicted way; a clean getx also invs the other sharers.
// swb/ack/ewb only update the directory of a hit way; an unknown kind is dropped in the accept cycle.
// One item is in flight at a time, set by the single shared tag compare and the row RAM.
// Reset is synchronous; afterwards a pass zeroes every set row before req_tready.
// The bank_id register resets to 0 and may be written at any time the bank is idle.
module l2_directory_bank_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // req_addr[41:0], requester[44:42], zero fill[47:45]
   input  logic [l2dir_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func[2:0]
   input  logic [l2dir_pkg::FUNC_W-1:0]        req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // dest_core[2:0], out_addr[44:3], origin_core[48:45], sharer_count[52:49],
   // from_bank[55:53]
   output logic [l2dir_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // msg_kind[2:0]
   output logic [l2dir_pkg::KIND_W-1:0]        rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [l2dir_pkg::BANK_W-1:0]        csr_data
);
   import l2dir_pkg::*;
`include "l2_directory_bank_controller_assert.svh"

   // Sequencer states.
   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_LOAD   = 4'd2;
   localparam logic [3:0] S_SCAN   = 4'd3;
   localparam logic [3:0] S_DECIDE = 4'd4;
   localparam logic [3:0] S_EVICT  = 4'd5;
   localparam logic [3:0] S_TOUCH  = 4'd6;
   localparam logic [3:0] S_REPLY  = 4'd7;
   localparam logic [3:0] S_GINV   = 4'd8;
   localparam logic [3:0] S_PUTX   = 4'd9;
   localparam logic [3:0] S_WB     = 4'd10;

   logic [3:0]            state_ff, state_in;
   logic [SET_W-1:0]      clr_ff, clr_in;
   logic [BANK_W-1:0]     bank_id_ff;
   logic [FUNC_W-1:0]     func_ff, func_in;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [CORE_W-1:0]     reqr_ff, reqr_in;
   row_type               row_ff, row_in, ram_q;
   logic [WAY_W-1:0]      way_ff, way_in;
   logic                  hit_ff, hit_in;
   logic [WAY_W-1:0]      hit_way_ff, hit_way_in;
   logic                  inv_ff, inv_in;
   logic [WAY_W-1:0]      inv_way_ff, inv_way_in;
   logic [AGE_W-1:0]      best_ff, best_in;
   logic [WAY_W-1:0]      vic_ff, vic_in;
   logic [WAY_W-1:0]      sel_ff, sel_in;
   logic [AGE_W-1:0]      old_ff, old_in;
   logic                  old_full_ff, old_full_in;
   logic [CORES-1:0]      ev_shr_ff, ev_shr_in;
   logic [TAG_W-1:0]      ev_tag_ff, ev_tag_in;
   logic [CORE_W-1:0]     core_ff, core_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]     o_kind_ff, o_kind_in;
   logic [CORE_W-1:0]     o_dest_ff, o_dest_in;
   logic [ADDR_BITS-1:0]  o_addr_ff, o_addr_in;
   logic [ORIG_W-1:0]     o_orig_ff, o_orig_in;
   logic [CNT_W-1:0]      o_cnt_ff, o_cnt_in;
   logic [BANK_W-1:0]     o_bank_ff, o_bank_in;
   logic                  o_last_ff, o_last_in;

   logic                  req_accept;
   logic                  slot_free;
   logic                  emit;
   logic                  ram_we;
   logic [SET_W-1:0]      ram_waddr;
   row_type               ram_wdata;
   logic [SET_W-1:0]      cur_set;
   logic [TAG_W-1:0]      cur_tag;
   logic [CORES-1:0]      rbit;
   logic [CORES-1:0]      sel_shr;
   logic [CORE_W-1:0]     owner;
   logic                  has_owner;
   logic [CNT_W-1:0]      shr_cnt;
   logic [CNT_W-1:0]      other_cnt;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign cur_set = addr_ff[BANK_W +: SET_W];
   assign cur_tag = addr_ff[BANK_W + SET_W +: TAG_W];
   assign rbit    = CORES'(1) << reqr_ff;
   assign sel_shr = row_ff.shr[sel_ff];

   // The owner of a dirty line is its highest-numbered sharer.
   always_comb begin
      owner     = '0;
      has_owner = 1'b0;
      shr_cnt   = '0;
      other_cnt = '0;
      for (int i = 0; i < CORES; i++) begin
         if (sel_shr[i]) begin
            owner     = CORE_W'(i);
            has_owner = 1'b1;
            shr_cnt   = shr_cnt + CNT_W'(1);
            if (!rbit[i]) begin
               other_cnt = other_cnt + CNT_W'(1);
            end
         end
      end
   end

   l2dir_row_ram u_row_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (req_accept),
      .raddr (req_tdata[BANK_W +: SET_W]),
      .rdata (ram_q)
   );

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      func_in     = func_ff;
      addr_in     = addr_ff;
      reqr_in     = reqr_ff;
      row_in      = row_ff;
      way_in      = way_ff;
      hit_in      = hit_ff;
      hit_way_in  = hit_way_ff;
      inv_in      = inv_ff;
      inv_way_in  = inv_way_ff;
      best_in     = best_ff;
      vic_in      = vic_ff;
      sel_in      = sel_ff;
      old_in      = old_ff;
      old_full_in = old_full_ff;
      ev_shr_in   = ev_shr_ff;
      ev_tag_in   = ev_tag_ff;
      core_in     = core_ff;
      ram_we      = 1'b0;
      ram_waddr   = cur_set;
      ram_wdata   = row_ff;
      emit        = 1'b0;
      o_kind_in   = o_kind_ff;
      o_dest_in   = o_dest_ff;
      o_addr_in   = o_addr_ff;
      o_orig_in   = o_orig_ff;
      o_cnt_in    = o_cnt_ff;
      o_bank_in   = o_bank_ff;
      o_last_in   = o_last_ff;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + SET_W'(1);
            if (clr_ff == SET_W'(SETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               func_in = req_tuser;
               addr_in = req_tdata[ADDR_BITS-1:0];
               reqr_in = req_tdata[ADDR_BITS +: CORE_W];
               // Unknown kinds are dropped here without any result.
               if (req_tuser <= FUNC_EWB) begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            row_in   = ram_q;
            way_in   = '0;
            hit_in   = 1'b0;
            inv_in   = 1'b0;
            best_in  = '0;
            vic_in   = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // One way per cycle through the shared tag and age compare.
            if (row_ff.vld[way_ff] && row_ff.tag[way_ff] == cur_tag && !hit_ff) begin
               hit_in     = 1'b1;
               hit_way_in = way_ff;
            end
            if (!row_ff.vld[way_ff] && !inv_ff) begin
               inv_in     = 1'b1;
               inv_way_in = way_ff;
            end
            if (row_ff.age[way_ff] > best_ff) begin
               best_in = row_ff.age[way_ff];
               vic_in  = way_ff;
            end
            way_in = way_ff + WAY_W'(1);
            if (way_ff == WAY_W'(WAYS - 1)) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (func_ff >= FUNC_SWB) begin
               // Directory-only updates; a missing tag is ignored.
               state_in = hit_ff ? S_WB : S_IDLE;
               if (hit_ff) begin
                  priority case (func_ff)
                     FUNC_SWB: begin
                        row_in.shr[hit_way_ff]   = row_ff.shr[hit_way_ff] | rbit;
                        row_in.dirty[hit_way_ff] = 1'b0;
                     end
                     FUNC_ACK: begin
                        row_in.dirty[hit_way_ff] = 1'b1;
                     end
                     default: begin
                        row_in.shr[hit_way_ff]   = row_ff.shr[hit_way_ff] & ~rbit;
                        row_in.dirty[hit_way_ff] = 1'b0;
                     end
                  endcase
               end
            end else if (hit_ff) begin
               sel_in      = hit_way_ff;
               old_in      = row_ff.age[hit_way_ff];
               old_full_in = 1'b0;
               state_in    = S_TOUCH;
            end else begin
               // Miss: fill an invalid way, else the oldest way after its invs.
               sel_in      = inv_ff ? inv_way_ff : vic_ff;
               old_full_in = 1'b1;
               ev_shr_in   = row_ff.shr[vic_ff];
               ev_tag_in   = row_ff.tag[vic_ff];
               core_in     = '0;
               state_in    = inv_ff ? S_TOUCH : S_EVICT;
               if (inv_ff) begin
                  row_in.vld[inv_way_ff]   = 1'b1;
                  row_in.tag[inv_way_ff]   = cur_tag;
                  row_in.shr[inv_way_ff]   = '0;
                  row_in.dirty[inv_way_ff] = 1'b0;
               end else begin
                  row_in.vld[vic_ff]   = 1'b1;
                  row_in.tag[vic_ff]   = cur_tag;
                  row_in.shr[vic_ff]   = '0;
                  row_in.dirty[vic_ff] = 1'b0;
               end
            end
         end
         S_EVICT: begin
            if (!ev_shr_ff[core_ff] || slot_free) begin
               if (ev_shr_ff[core_ff]) begin
                  emit      = 1'b1;
                  o_kind_in = MSG_INV;
                  o_dest_in = core_ff;
                  o_addr_in = {ev_tag_ff, cur_set, addr_ff[BANK_W-1:0]};
                  o_orig_in = NO_CORE;
                  o_cnt_in  = '0;
                  o_last_in = 1'b0;
               end
               core_in = core_ff + CORE_W'(1);
               if (core_ff == CORE_W'(CORES - 1)) begin
                  state_in = S_TOUCH;
               end
            end
         end
         S_TOUCH: begin
            // Valid lines younger than the touched one, or all other valid lines on a miss, age by one.
            for (int v = 0; v < WAYS; v++) begin
               if (WAY_W'(v) != sel_ff && row_ff.vld[v] &&
                   (old_full_ff || row_ff.age[v] < old_ff) &&
                   row_ff.age[v] < AGE_W'(WAYS - 1)) begin
                  row_in.age[v] = row_ff.age[v] + AGE_W'(1);
               end
            end
            row_in.age[sel_ff] = '0;
            state_in = S_REPLY;
         end
         S_REPLY: begin
            if (row_ff.dirty[sel_ff] && has_owner) begin
               // Dirty line: forward to its owner.
               if (slot_free) begin
                  emit      = 1'b1;
                  o_kind_in = (func_ff == FUNC_GET) ? MSG_GET : MSG_GETX;
                  o_dest_in = owner;
                  o_addr_in = addr_ff;
                  o_orig_in = ORIG_W'(reqr_ff);
                  o_cnt_in  = (func_ff == FUNC_GET) ? CNT_W'(1) : CNT_W'(0);
                  o_last_in = 1'b1;
                  if (func_ff == FUNC_GET) begin
                     row_in.shr[sel_ff] = sel_shr | rbit;
                  end else begin
                     row_in.shr[sel_ff]   = (sel_shr & ~(CORES'(1) << owner)) | rbit;
                     row_in.dirty[sel_ff] = 1'b1;
                  end
                  state_in = S_WB;
               end
            end else if (func_ff == FUNC_GET) begin
               if (slot_free) begin
                  emit      = 1'b1;
                  o_kind_in = MSG_PUT;
                  o_dest_in = reqr_ff;
                  o_addr_in = addr_ff;
                  o_orig_in = NO_CORE;
                  o_cnt_in  = shr_cnt;
                  o_last_in = 1'b1;
                  row_in.shr[sel_ff]   = sel_shr | rbit;
                  row_in.dirty[sel_ff] = (shr_cnt == '0);
                  state_in = S_WB;
               end
            end else begin
               core_in  = '0;
               state_in = S_GINV;
            end
         end
         S_GINV: begin
            // Invalidate every other sharer; the requester itself is skipped.
            if (!sel_shr[core_ff] || rbit[core_ff] || slot_free) begin
               if (sel_shr[core_ff] && !rbit[core_ff]) begin
                  emit      = 1'b1;
                  o_kind_in = MSG_INV;
                  o_dest_in = core_ff;
                  o_addr_in = addr_ff;
                  o_orig_in = ORIG_W'(reqr_ff);
                  o_cnt_in  = '0;
                  o_last_in = 1'b0;
               end
               core_in = core_ff + CORE_W'(1);
               if (core_ff == CORE_W'(CORES - 1)) begin
                  state_in = S_PUTX;
               end
            end
         end
         S_PUTX: begin
            if (slot_free) begin
               emit      = 1'b1;
               o_kind_in = MSG_PUTX;
               o_dest_in = reqr_ff;
               o_addr_in = addr_ff;
               o_orig_in = NO_CORE;
               o_cnt_in  = other_cnt;
               o_last_in = 1'b1;
               row_in.shr[sel_ff]   = rbit;
               row_in.dirty[sel_ff] = 1'b1;
               state_in = S_WB;
            end
         end
         S_WB: begin
            ram_we   = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         o_bank_in = bank_id_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         bank_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            bank_id_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      addr_ff     <= addr_in;
      reqr_ff     <= reqr_in;
      row_ff      <= row_in;
      way_ff      <= way_in;
      hit_ff      <= hit_in;
      hit_way_ff  <= hit_way_in;
      inv_ff      <= inv_in;
      inv_way_ff  <= inv_way_in;
      best_ff     <= best_in;
      vic_ff      <= vic_in;
      sel_ff      <= sel_in;
      old_ff      <= old_in;
      old_full_ff <= old_full_in;
      ev_shr_ff   <= ev_shr_in;
      ev_tag_ff   <= ev_tag_in;
      core_ff     <= core_in;
      o_kind_ff   <= o_kind_in;
      o_dest_ff   <= o_dest_in;
      o_addr_ff   <= o_addr_in;
      o_orig_ff   <= o_orig_in;
      o_cnt_ff    <= o_cnt_in;
      o_bank_ff   <= o_bank_in;
      o_last_ff   <= o_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = o_kind_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {o_bank_ff, o_cnt_ff, o_orig_ff, o_addr_ff, o_dest_ff};

   // A known kind keeps the bank busy after it is taken.
   `L2DIR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept && req_tuser <= FUNC_EWB, !req_tready, "bank ready right after taking a request")
   // Results only leave from the emitting states.
   `L2DIR_ASSERT_NOW(a_emit_state, clock, reset, emit, state_ff == S_EVICT || state_ff == S_REPLY || state_ff == S_GINV || state_ff == S_PUTX, "result loaded outside an emitting state")
   // The way being touched is always installed or hit.
   `L2DIR_ASSERT_NOW(a_touch_valid, clock, reset, state_ff == S_TOUCH, row_ff.vld[sel_ff], "LRU touch on an invalid way")
   // A new result never overwrites one that is still waiting.
   `L2DIR_ASSERT_NOW(a_no_overwrite, clock, reset, emit, slot_free, "result register overwritten while stalled")

endmodule

// ===== rtl/l2dir_row_ram.sv =====
// Set-wide storage of the directory bank: one row per set, one write and one read port.
// Depends on l2dir_pkg for the row type and the set count.
module l2dir_row_ram (
   input  logic                            clock,
   input  logic                            we,
   input  logic [l2dir_pkg::SET_W-1:0]     waddr,
   input  l2dir_pkg::row_type              wdata,
   input  logic                            re,
   input  logic [l2dir_pkg::SET_W-1:0]     raddr,
   output l2dir_pkg::row_type              rdata
);
   import l2dir_pkg::*;

   row_type mem [SETS];
   row_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the L2 directory bank controller.
// Depends on l2dir_pkg and the l2_directory_bank_controller RTL.
`timescale 1ns / 1ps

module tb_top;
   import l2dir_pkg::*;

   localparam int LINES = SETS * WAYS;
   localparam longint unsigned CYCLE_LIMIT = 400000;
   localparam int HOLD_LEN = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [BANK_W-1:0]     csr_data = '0;

   l2_directory_bank_controller DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // One outgoing coherence message as the bank should send it.
   typedef struct {
      logic [KIND_W-1:0]    kind;
      logic [CORE_W-1:0]    dest;
      logic [ADDR_BITS-1:0] addr;
      logic [ORIG_W-1:0]    origin;
      logic [CNT_W-1:0]     cnt;
      logic [BANK_W-1:0]    bank;
      logic                 last;
   } coh_msg_type;

   // Shadow directory of the bank.
   logic [BANK_W-1:0] shadow_bank_id;
   logic              dir_valid  [LINES];
   logic [TAG_W-1:0]  dir_tag    [LINES];
   logic [CORES-1:0]  dir_sharers[LINES];
   logic              dir_dirty  [LINES];
   logic [AGE_W-1:0]  dir_age    [LINES];

   coh_msg_type pending_msgs[$];
   bit       failed = 1'b0;
   longint unsigned cycle_count = 0;

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_requests = 0; // raised by a test to ask for a long receiver hold-off
   int  hold_served = 0;   // hold-off requests already taken by the receiver
   int  hold_cycles = 0;   // receiver hold-off counted by the stall process

   // Small pool of set indexes and tags so hits, evictions and LRU reuse occur.
   logic [SET_W-1:0] hot_sets[4];
   logic [TAG_W-1:0] hot_tags[24];

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         hold_cycles <= HOLD_LEN;
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Result checker: every accepted message is compared against the oldest expectation.
   always @(posedge clock) begin
      coh_msg_type exp_m;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_msgs.size() == 0) begin
            $error("unexpected message kind=%0d dest=%0d", rsp_tuser, rsp_tdata[2:0]);
            failed = 1'b1;
         end else begin
            exp_m = pending_msgs.pop_front();
            if (rsp_tuser !== exp_m.kind) begin
               $error("msg_kind expected %0d got %0d", exp_m.kind, rsp_tuser);
               failed = 1'b1;
            end
            if (rsp_tdata[2:0] !== exp_m.dest) begin
               $error("dest_core expected %0d got %0d", exp_m.dest, rsp_tdata[2:0]);
               failed = 1'b1;
            end
            if (rsp_tdata[44:3] !== exp_m.addr) begin
               $error("out_addr expected %h got %h", exp_m.addr, rsp_tdata[44:3]);
               failed = 1'b1;
            end
            if (rsp_tdata[48:45] !== exp_m.origin) begin
               $error("origin_core expected %0d got %0d", exp_m.origin, rsp_tdata[48:45]);
               failed = 1'b1;
            end
            if (rsp_tdata[52:49] !== exp_m.cnt) begin
               $error("sharer_count expected %0d got %0d", exp_m.cnt, rsp_tdata[52:49]);
               failed = 1'b1;
            end
            if (rsp_tdata[55:53] !== exp_m.bank) begin
               $error("from_bank expected %0d got %0d", exp_m.bank, rsp_tdata[55:53]);
               failed = 1'b1;
            end
            if (rsp_tlast !== exp_m.last) begin
               $error("last expected %0d got %0d", exp_m.last, rsp_tlast);
               failed = 1'b1;
            end
         end
      end
   end

   function automatic void queue_msg(int unsigned kind, int unsigned dest,
                                     logic [ADDR_BITS-1:0] addr, int unsigned origin,
                                     int unsigned cnt, ref int n);
      coh_msg_type m;
      if (n >= WAYS) return;
      m.kind = kind[KIND_W-1:0];
      m.dest = dest[CORE_W-1:0];
      m.addr = addr;
      m.origin = origin[ORIG_W-1:0];
      m.cnt = cnt[CNT_W-1:0];
      m.bank = shadow_bank_id;
      m.last = 1'b0;
      pending_msgs.push_back(m);
      n++;
   endfunction

   // Directory update and message prediction for one request.
   function automatic void predict_directory(logic [FUNC_W-1:0] func,
                                             logic [ADDR_BITS-1:0] addr,
                                             logic [CORE_W-1:0] req);
      logic [SET_W-1:0] set_idx;
      logic [TAG_W-1:0] tag;
      logic [BANK_W-1:0] bank;
      logic [CORES-1:0] rbit;
      int base, hit, pick, w, old, owner, n, cnt, line, best;
      coh_msg_type m;
      bank = addr[2:0];
      set_idx = addr[SET_W+2:3];
      tag = addr[ADDR_BITS-1:SET_W+3];
      base = int'(set_idx) * WAYS;
      rbit = '0;
      rbit[req] = 1'b1;
      hit = -1;
      owner = -1;
      n = 0;
      if (func > FUNC_EWB) return;
      for (w = 0; w < WAYS; w++)
         if (hit < 0 && dir_valid[base+w] && dir_tag[base+w] == tag) hit = w;
      if (func != FUNC_GET && func != FUNC_GETX) begin
         if (hit < 0) return;
         line = base + hit;
         if (func == FUNC_SWB) begin
            dir_sharers[line] |= rbit;
            dir_dirty[line] = 1'b0;
         end else if (func == FUNC_ACK) begin
            dir_dirty[line] = 1'b1;
         end else begin
            dir_sharers[line] &= ~rbit;
            dir_dirty[line] = 1'b0;
         end
         return;
      end
      if (hit >= 0) begin
         w = hit;
         old = dir_age[base+w];
      end else begin
         pick = -1;
         for (w = 0; w < WAYS; w++)
            if (pick < 0 && !dir_valid[base+w]) pick = w;
         if (pick < 0) begin
            best = 0;
            pick = 0;
            for (w = 0; w < WAYS; w++)
               if (dir_age[base+w] > best) begin
                  best = dir_age[base+w];
                  pick = w;
               end
            line = base + pick;
            for (int i = 0; i < CORES; i++)
               if (dir_sharers[line][i] && n < WAYS - 1)
                  queue_msg(MSG_INV, i, {dir_tag[line], set_idx, bank},
                            NO_CORE, 0, n);
         end
         w = pick;
         line = base + w;
         dir_valid[line] = 1'b1;
         dir_tag[line] = tag;
         dir_sharers[line] = '0;
         dir_dirty[line] = 1'b0;
         old = WAYS;
      end
      // LRU: touched way becomes youngest, younger valid ways (all others on a miss) age by one.
      for (int v = 0; v < WAYS; v++)
         if (v != w && dir_valid[base+v] && dir_age[base+v] < old &&
             dir_age[base+v] < WAYS-1)
            dir_age[base+v]++;
      dir_age[base+w] = '0;
      line = base + w;
      for (int i = 0; i < CORES; i++)
         if (dir_sharers[line][i]) owner = i;
      cnt = 0;
      if (func == FUNC_GET) begin
         if (dir_dirty[line] && owner >= 0) begin
            queue_msg(MSG_GET, owner, addr, req, 1, n);
            dir_sharers[line] |= rbit;
         end else begin
            cnt = $countones(dir_sharers[line]);
            queue_msg(MSG_PUT, req, addr, NO_CORE, cnt, n);
            dir_sharers[line] |= rbit;
            dir_dirty[line] = (cnt == 0);
         end
      end else begin
         if (dir_dirty[line] && owner >= 0) begin
            queue_msg(MSG_GETX, owner, addr, req, 0, n);
            dir_sharers[line][owner] = 1'b0;
            dir_sharers[line] |= rbit;
         end else begin
            for (int i = 0; i < CORES; i++)
               if (i != req && dir_sharers[line][i]) begin
                  cnt++;
                  if (n < WAYS - 1) queue_msg(MSG_INV, i, addr, req, 0, n);
                  dir_sharers[line][i] = 1'b0;
               end
            queue_msg(MSG_PUTX, req, addr, NO_CORE, cnt, n);
            dir_sharers[line] |= rbit;
         end
         dir_dirty[line] = 1'b1;
      end
      if (n > 0) begin
         m = pending_msgs[$];
         m.last = 1'b1;
         pending_msgs[$] = m;
      end
   endfunction

   // Offers one request, waits for acceptance, then predicts its messages.
   // The valid stays up after acceptance; the next request or drain decides it.
   task automatic send_request(logic [FUNC_W-1:0] func, logic [ADDR_BITS-1:0] addr,
                               logic [CORE_W-1:0] req);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {3'b000, req, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_directory(func, addr, req);
   endtask

   // Waits until every expected message arrived, then for the bank to settle.
   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_msgs.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_bank_id(logic [BANK_W-1:0] id);
      csr_valid <= 1'b1;
      csr_data <= id;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      shadow_bank_id = id;
   endtask

   function automatic logic [ADDR_BITS-1:0] hot_addr;
      return {hot_tags[$urandom_range(23)], hot_sets[$urandom_range(3)],
              (($urandom_range(9) == 0) ? 3'($urandom) : shadow_bank_id)};
   endfunction

   // Directed: every kind, field extremes, dirty forwarding, set eviction.
   task automatic test_directed;
      logic [ADDR_BITS-1:0] a;
      a = {hot_tags[0], hot_sets[0], 3'd0};
      write_bank_id(3'd0);
      send_request(FUNC_SWB, a, 3'd1);           // missing tag: ignored
      send_request(FUNC_GET, a, 3'd0);           // miss, fill, clean put
      send_request(FUNC_GET, a, 3'd7);           // owner dirty: forwarded get
      send_request(FUNC_SWB, a, 3'd0);
      send_request(FUNC_GET, a, 3'd3);           // clean put with sharers
      send_request(FUNC_GETX, a, 3'd3);          // invs to other sharers
      send_request(FUNC_ACK, a, 3'd3);
      send_request(FUNC_GETX, a, 3'd5);          // forwarded getx
      send_request(FUNC_EWB, a, 3'd5);           // leaves a clean line with no sharer
      send_request(FUNC_GET, a, 3'd2);
      send_request(3'd5, a, 3'd1);               // unknown kinds
      send_request(3'd7, '1, 3'd7);
      send_request(FUNC_GET, '1, 3'd7);          // all-ones address
      send_request(FUNC_GETX, '0, 3'd0);
      // Fill one set beyond its ways so evictions send invs to sharers.
      for (int t = 0; t < WAYS + 2; t++)
         send_request((t % 2) ? FUNC_GETX : FUNC_GET,
                      {hot_tags[t], hot_sets[1], 3'd0}, 3'(t));
      drain();
   endtask

   // Random: mostly well-formed traffic on a few hot sets, some noise.
   task automatic test_random(int items, int idle_pct, int stall_pct);
      int r;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int k = 0; k < items; k++) begin
         r = $urandom_range(99);
         if (r < 4)
            send_request(3'($urandom_range(7, 5)), ADDR_BITS'({$urandom, $urandom}),
                         3'($urandom));
         else if (r < 10)
            send_request(3'($urandom_range(4)), ADDR_BITS'({$urandom, $urandom}),
                         3'($urandom));
         else
            send_request(3'($urandom_range(4)), hot_addr(), 3'($urandom));
      end
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   // Receiver holds off while requests keep arriving, so the bank backs up.
   task automatic test_backpressure;
      hold_requests = hold_requests + 1;
      for (int k = 0; k < 12; k++)
         send_request((k % 2) ? FUNC_GETX : FUNC_GET, hot_addr(), 3'($urandom));
      drain();
   endtask

   initial begin
      shadow_bank_id = '0;
      for (int i = 0; i < LINES; i++) begin
         dir_valid[i] = 1'b0;
         dir_tag[i] = '0;
         dir_sharers[i] = '0;
         dir_dirty[i] = 1'b0;
         dir_age[i] = '0;
      end
      for (int i = 0; i < 4; i++) hot_sets[i] = SET_W'($urandom);
      hot_sets[0] = '0;
      hot_sets[3] = '1;
      for (int i = 0; i < 24; i++) hot_tags[i] = TAG_W'({$urandom, $urandom});
      hot_tags[2] = '1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      write_bank_id(3'd7);
      test_random(35, 0, 0);
      write_bank_id(3'd3);
      test_random(35, 53, 0);
      write_bank_id(3'd5);
      test_random(35, 0, 53);
      write_bank_id(3'd2);
      test_random(35, 18, 18);
      test_backpressure();

      if (!failed) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/l2dir_pkg.sv
rtl/l2dir_row_ram.sv
rtl/l2_directory_bank_controller.sv
tb/tb_top.sv
